FILE: rtl/rfd_pkg.sv
// Package: shared constants, types and a helper function for the record field decoder.
`timescale 1ns / 1ps
package rfd_pkg;

  localparam int MAX_FIELDS = 16;
  localparam int IDX_W      = $clog2(MAX_FIELDS);
  localparam int TC_W       = $clog2(MAX_FIELDS + 1);
  localparam int TYPE_W     = 18;
  localparam int LEN_W      = 17;

  // Parse phases of one cell
  typedef enum logic [2:0] {
    PH_SKIP1 = 3'd0,
    PH_SKIP2 = 3'd1,
    PH_HLEN  = 3'd2,
    PH_HDR   = 3'd3,
    PH_DATA  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  // Result kinds
  typedef enum logic [3:0] {
    K_NULL   = 4'd0,
    K_INT    = 4'd1,
    K_FLOAT  = 4'd2,
    K_BLOB   = 4'd3,
    K_TEXT   = 4'd4,
    K_EBLOB  = 4'd5,
    K_ETEXT  = 4'd6,
    K_RSVD   = 4'd7,
    K_ERR    = 4'd8
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic step;   // process the accepted byte
    logic begin_f; // load byte count of the current field
    logic drain;  // emit the current bytes-free field
  } rfd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic res_load;   // this step's transfer produced a result
    logic begin_pend; // current field needs its byte count loaded
    logic drain_pend; // current field has no data bytes
  } rfd_stat_t;

  // Number of data bytes for a serial type
  function automatic logic [LEN_W-1:0] data_len(input logic [TYPE_W-1:0] t);
    logic [TYPE_W-1:0] d;
    begin
      d = t - TYPE_W'(12);
      case (t)
        TYPE_W'(1): data_len = LEN_W'(1);
        TYPE_W'(2): data_len = LEN_W'(2);
        TYPE_W'(3): data_len = LEN_W'(3);
        TYPE_W'(4): data_len = LEN_W'(4);
        TYPE_W'(5): data_len = LEN_W'(6);
        TYPE_W'(6): data_len = LEN_W'(8);
        TYPE_W'(7): data_len = LEN_W'(8);
        default: begin
          if (t < TYPE_W'(12)) data_len = '0;
          else data_len = d[TYPE_W-1:1];
        end
      endcase
    end
  endfunction

endpackage

FILE: rtl/rfd_ctrl.sv
// Controller: sequences byte transfers, result transfers and bytes-free fields.
`timescale 1ns / 1ps
module rfd_ctrl
  import rfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rfd_stat_t stat,
  output rfd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IN  = 3'b001,
    ST_RES = 3'b010,
    ST_CHK = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IN);
  assign out_valid = (state_r == ST_RES);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.step    = 1'b0;
    cmd.begin_f = 1'b0;
    cmd.drain   = 1'b0;
    case (state_r)
      ST_IN: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          state_nxt = stat.res_load ? ST_RES : ST_CHK;
        end
      end
      ST_RES: begin
        if (out_ready) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (stat.begin_pend) begin
          cmd.begin_f = 1'b1;
        end else if (stat.drain_pend) begin
          cmd.drain = 1'b1;
          state_nxt = ST_RES;
        end else begin
          state_nxt = ST_IN;
        end
      end
      default: state_nxt = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IN;
    else state_r <= state_nxt;
  end

endmodule

FILE: rtl/rfd_datapath.sv
// Datapath: parse state, serial type store, value assembly and result register.
`timescale 1ns / 1ps
module rfd_datapath
  import rfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  rfd_cmd_t           cmd,
  output rfd_stat_t          stat,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_of_cell,
  output logic [5:0]         out_field_index,
  output logic [3:0]         out_kind,
  output logic signed [63:0] out_field_value,
  output logic               out_last_of_field,
  output logic               out_last_of_record
);

  phase_t             phase_r, phase_nxt;
  logic [3:0]         vcnt_r, vcnt_nxt;
  logic [7:0]         hlen_r, hlen_nxt;
  logic [7:0]         hread_r, hread_nxt;
  logic [TYPE_W-1:0]  vacc_r, vacc_nxt;
  logic               vbig_r, vbig_nxt;
  logic [TC_W-1:0]    tc_r, tc_nxt;
  logic [TC_W-1:0]    cf_r, cf_nxt;
  logic [LEN_W-1:0]   br_r, br_nxt;
  logic [63:0]        val_r, val_nxt;
  logic               bp_r, bp_nxt;
  logic [TYPE_W-1:0]  types_r [MAX_FIELDS];

  logic               wr_en;
  logic [TYPE_W-1:0]  wr_data;
  logic               res_en;
  logic [5:0]         res_idx;
  kind_t              res_kind;
  logic [63:0]        res_val;
  logic               res_lf, res_lr;
  logic [5:0]         fidx_r;
  logic [3:0]         kind_r;
  logic [63:0]        fval_r;
  logic               lf_r, lr_r;

  logic [TYPE_W-1:0]  ctype;
  logic [TYPE_W+7:0]  wide;
  logic               done_v;
  logic [LEN_W-1:0]   brn;
  logic [63:0]        acc;
  logic [63:0]        sx;
  logic               last_f;

  assign ctype  = (cf_r < TC_W'(MAX_FIELDS)) ? types_r[cf_r[IDX_W-1:0]] : '0;
  assign last_f = ({1'b0, cf_r} + 1'b1) >= {1'b0, tc_r};

  assign stat.begin_pend = bp_r;
  assign stat.drain_pend = (phase_r == PH_DATA) && (cf_r < tc_r) &&
                           (br_r == '0) && !bp_r;
  assign stat.res_load   = res_en;

  // sign extension of a finished big-endian integer
  always_comb begin
    acc = {val_r[55:0], in_data_byte};
    case (ctype)
      TYPE_W'(1): sx = {{56{acc[7]}}, acc[7:0]};
      TYPE_W'(2): sx = {{48{acc[15]}}, acc[15:0]};
      TYPE_W'(3): sx = {{40{acc[23]}}, acc[23:0]};
      TYPE_W'(4): sx = {{32{acc[31]}}, acc[31:0]};
      TYPE_W'(5): sx = {{16{acc[47]}}, acc[47:0]};
      default:    sx = acc;
    endcase
  end

  // next-state logic for step, field begin and drain
  always_comb begin
    phase_nxt = phase_r;
    vcnt_nxt  = vcnt_r;
    hlen_nxt  = hlen_r;
    hread_nxt = hread_r;
    vacc_nxt  = vacc_r;
    vbig_nxt  = vbig_r;
    tc_nxt    = tc_r;
    cf_nxt    = cf_r;
    br_nxt    = br_r;
    val_nxt   = val_r;
    bp_nxt    = bp_r;
    wr_en     = 1'b0;
    wr_data   = '0;
    res_en    = 1'b0;
    res_idx   = {{(6-TC_W){1'b0}}, cf_r};
    res_kind  = K_NULL;
    res_val   = '0;
    res_lf    = 1'b1;
    res_lr    = 1'b1;
    wide      = '0;
    done_v    = 1'b0;
    brn       = br_r - 1'b1;

    if (cmd.step) begin
      if (in_first_of_cell) begin
        phase_nxt = PH_SKIP1;
        vcnt_nxt  = '0;
        hlen_nxt  = '0;
        hread_nxt = '0;
        vacc_nxt  = '0;
        vbig_nxt  = 1'b0;
        tc_nxt    = '0;
        cf_nxt    = '0;
        br_nxt    = '0;
        val_nxt   = '0;
        bp_nxt    = 1'b0;
      end
      brn = br_nxt - 1'b1;
      case (phase_nxt)
        PH_SKIP1, PH_SKIP2: begin
          if (!in_data_byte[7] || vcnt_nxt >= 4'd8) begin
            vcnt_nxt  = '0;
            phase_nxt = (phase_nxt == PH_SKIP1) ? PH_SKIP2 : PH_HLEN;
          end else begin
            vcnt_nxt = vcnt_nxt + 1'b1;
          end
        end
        PH_HLEN: begin
          hlen_nxt  = in_data_byte;
          hread_nxt = 8'd1;
          tc_nxt    = '0;
          phase_nxt = (in_data_byte <= 8'd1) ? PH_DONE : PH_HDR;
        end
        PH_HDR: begin
          if (hread_nxt != 8'd255) hread_nxt = hread_nxt + 1'b1;
          if (vcnt_nxt < 4'd8) begin
            wide     = {1'b0, vacc_nxt, in_data_byte[6:0]};
            vcnt_nxt = vcnt_nxt + 1'b1;
            done_v   = !in_data_byte[7];
          end else begin
            wide   = {vacc_nxt, in_data_byte};
            done_v = 1'b1;
          end
          vbig_nxt = vbig_nxt | (|wide[TYPE_W+7:TYPE_W]);
          vacc_nxt = wide[TYPE_W-1:0];
          if (done_v) begin
            if (tc_nxt >= TC_W'(MAX_FIELDS) || vbig_nxt) begin
              res_en    = 1'b1;
              res_idx   = {{(6-TC_W){1'b0}}, tc_nxt};
              res_kind  = K_ERR;
              phase_nxt = PH_DONE;
            end else begin
              wr_en    = 1'b1;
              wr_data  = vacc_nxt;
              tc_nxt   = tc_nxt + 1'b1;
              vacc_nxt = '0;
              vbig_nxt = 1'b0;
              vcnt_nxt = '0;
              if (hread_nxt >= hlen_nxt) begin
                phase_nxt = PH_DATA;
                cf_nxt    = '0;
                bp_nxt    = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          if (cf_r < tc_r && br_r != '0) begin
            br_nxt = brn;
            res_lr = (brn == '0) && last_f;
            res_lf = (brn == '0);
            if (ctype >= TYPE_W'(12)) begin
              res_en   = 1'b1;
              res_kind = ctype[0] ? K_TEXT : K_BLOB;
              res_val  = {56'd0, in_data_byte};
            end else begin
              val_nxt = acc;
              if (brn == '0) begin
                res_en   = 1'b1;
                res_kind = (ctype == TYPE_W'(7)) ? K_FLOAT : K_INT;
                res_val  = (ctype == TYPE_W'(7)) ? acc : sx;
              end
            end
            if (brn == '0) begin
              cf_nxt = cf_r + 1'b1;
              if (last_f) phase_nxt = PH_DONE;
              else bp_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.begin_f) begin
      bp_nxt  = 1'b0;
      val_nxt = '0;
      br_nxt  = (cf_r < tc_r) ? data_len(ctype) : '0;
    end else if (cmd.drain) begin
      res_en = 1'b1;
      res_lr = last_f;
      case (ctype)
        TYPE_W'(0): res_kind = K_NULL;
        TYPE_W'(8): res_kind = K_INT;
        TYPE_W'(9): begin
          res_kind = K_INT;
          res_val  = 64'd1;
        end
        TYPE_W'(10), TYPE_W'(11): res_kind = K_RSVD;
        default: res_kind = ctype[0] ? K_ETEXT : K_EBLOB;
      endcase
      cf_nxt = cf_r + 1'b1;
      if (last_f) phase_nxt = PH_DONE;
      else bp_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP1;
      vcnt_r  <= '0;
      hlen_r  <= '0;
      hread_r <= '0;
      vacc_r  <= '0;
      vbig_r  <= 1'b0;
      tc_r    <= '0;
      cf_r    <= '0;
      br_r    <= '0;
      val_r   <= '0;
      bp_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      vcnt_r  <= vcnt_nxt;
      hlen_r  <= hlen_nxt;
      hread_r <= hread_nxt;
      vacc_r  <= vacc_nxt;
      vbig_r  <= vbig_nxt;
      tc_r    <= tc_nxt;
      cf_r    <= cf_nxt;
      br_r    <= br_nxt;
      val_r   <= val_nxt;
      bp_r    <= bp_nxt;
    end
  end

  // serial type store and result register
  always_ff @(posedge clk) begin
    if (wr_en) types_r[tc_r[IDX_W-1:0]] <= wr_data;
    if (res_en) begin
      fidx_r <= res_idx;
      kind_r <= res_kind;
      fval_r <= res_val;
      lf_r   <= res_lf;
      lr_r   <= res_lr;
    end
  end

  assign out_field_index    = fidx_r;
  assign out_kind           = kind_r;
  assign out_field_value    = fval_r;
  assign out_last_of_field  = lf_r;
  assign out_last_of_record = lr_r;

endmodule

FILE: rtl/record_field_decoder.sv
// Top level: record field decoder, controller plus datapath.
//
// Takes a leaf table cell one byte per input transfer (in_data_byte, with
// in_first_of_cell set on the first byte of a cell) and produces one result
// per field, or one per blob/text byte, on the out_ channel.
// Both channels use valid/ready; a transfer happens when both are high.
// Each byte is accepted in the input state. A byte with no result goes straight
// to the check state; a byte that yields a result holds the result in the
// output register until the receiver takes it, then the check state follows.
// Every field has its length loaded in the check state once it becomes
// current; one without data bytes is then emitted into the output register
// and handed over like any other result.
// The header store is a 16-entry register array written once per type.
// in_ready is low while a result waits or fields without data are emitted,
// so a stalled receiver holds the input side as well.
// After reset the parser waits for the first byte of a cell; no clearing
// pass is needed.
`timescale 1ns / 1ps
module record_field_decoder
  import rfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               in_first_of_cell,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_field_index,
  output logic [3:0]         out_kind,
  output logic signed [63:0] out_field_value,
  output logic               out_last_of_field,
  output logic               out_last_of_record
);

  rfd_cmd_t  cmd;
  rfd_stat_t stat;

  rfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfd_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_data_byte       (in_data_byte),
    .in_first_of_cell   (in_first_of_cell),
    .out_field_index    (out_field_index),
    .out_kind           (out_kind),
    .out_field_value    (out_field_value),
    .out_last_of_field  (out_last_of_field),
    .out_last_of_record (out_last_of_record)
  );

endmodule

FILE: verif/tb_top.sv
// Testbench for the record field decoder: predicts each result and checks every out_ transfer.
`timescale 1ns / 1ps
module tb_top
  import rfd_pkg::*;
();

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_data_byte;
  logic in_first_of_cell;
  logic out_valid;
  logic out_ready;
  logic [5:0] out_field_index;
  logic [3:0] out_kind;
  logic signed [63:0] out_field_value;
  logic out_last_of_field;
  logic out_last_of_record;

  record_field_decoder dut (.*);

  typedef struct packed {
    logic [5:0]  idx;
    logic [3:0]  kind;
    logic [63:0] value;
    logic        lf;
    logic        lr;
  } field_res_t;

  localparam int RES_LIMIT = 16;
  localparam int TYPE_MAX  = 'h3FFFF;
  localparam longint CYCLE_LIMIT = 400000;

  // predictor state
  phase_t      p_phase;
  logic [63:0] p_vacc;
  int unsigned p_vcnt;
  int unsigned p_hlen;
  int unsigned p_hread;
  int unsigned p_types[MAX_FIELDS];
  int unsigned p_tcount;
  int unsigned p_cur;
  int unsigned p_remain;
  logic [63:0] p_val;

  field_res_t expected_q[$];
  int  error_count;
  longint cycle_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  logic hold_off;

  function automatic int unsigned byte_count(int unsigned t);
    int unsigned lens[12] = '{0, 1, 2, 3, 4, 6, 8, 8, 0, 0, 0, 0};
    if (t < 12) return lens[t];
    return (t - 12) >> 1;
  endfunction

  function automatic void push_res(int unsigned idx, kind_t k, logic [63:0] v,
                                   bit lf, bit lr, ref int n);
    field_res_t r;
    r.idx = idx[5:0];
    r.kind = k;
    r.value = v;
    r.lf = lf;
    r.lr = lr;
    expected_q.push_back(r);
    n++;
  endfunction

  function automatic void open_field();
    p_val = 0;
    p_remain = (p_cur < p_tcount) ? byte_count(p_types[p_cur]) : 0;
  endfunction

  function automatic void next_field();
    p_cur++;
    if (p_cur >= p_tcount) p_phase = PH_DONE;
    else open_field();
  endfunction

  // emit fields that carry no bytes, up to the per-step limit
  function automatic void emit_empty(ref int n, input int lim);
    int unsigned t;
    kind_t k;
    logic [63:0] v;
    while (p_phase == PH_DATA && p_cur < p_tcount && p_remain == 0 && n < lim) begin
      t = p_types[p_cur];
      v = 0;
      if (t == 0) k = K_NULL;
      else if (t == 8) k = K_INT;
      else if (t == 9) begin
        k = K_INT;
        v = 1;
      end else if (t == 10 || t == 11) k = K_RSVD;
      else if (t[0] == 1'b0) k = K_EBLOB;
      else k = K_ETEXT;
      push_res(p_cur, k, v, 1, p_cur + 1 >= p_tcount, n);
      next_field();
    end
  endfunction

  function automatic void take_data(logic [7:0] b, ref int n);
    int unsigned t;
    int unsigned bits;
    bit lr;
    logic [63:0] v;
    t = p_types[p_cur];
    p_remain--;
    lr = (p_remain == 0) && (p_cur + 1 >= p_tcount);
    if (t >= 12) begin
      push_res(p_cur, t[0] ? K_TEXT : K_BLOB, {56'd0, b}, p_remain == 0, lr, n);
      if (p_remain == 0) next_field();
      return;
    end
    p_val = (p_val << 8) | b;
    if (p_remain != 0) return;
    if (t == 7) push_res(p_cur, K_FLOAT, p_val, 1, lr, n);
    else begin
      bits = byte_count(t) * 8;
      v = p_val;
      if (bits < 64 && v[bits-1]) v = v | ~((64'd1 << bits) - 1);
      push_res(p_cur, K_INT, v, 1, lr, n);
    end
    next_field();
  endfunction

  function automatic void clear_parser();
    p_phase = PH_SKIP1;
    p_vacc = 0;
    p_vcnt = 0;
    p_hlen = 0;
    p_hread = 0;
    p_tcount = 0;
    p_cur = 0;
    p_remain = 0;
    p_val = 0;
  endfunction

  // work out the results one accepted byte causes
  function automatic void predict_byte(logic [7:0] b, bit first);
    int n;
    bit done_v;
    n = 0;
    done_v = 0;
    if (first) clear_parser();
    case (p_phase)
      PH_SKIP1, PH_SKIP2: begin
        p_vcnt++;
        if (!b[7] || p_vcnt >= 9) begin
          p_vcnt = 0;
          p_phase = phase_t'(p_phase + 1);
        end
      end
      PH_HLEN: begin
        p_hlen = b;
        p_hread = 1;
        p_tcount = 0;
        p_phase = (b <= 1) ? PH_DONE : PH_HDR;
      end
      PH_HDR: begin
        if (p_hread < 255) p_hread++;
        if (p_vcnt < 8) begin
          p_vacc = (p_vacc << 7) | b[6:0];
          p_vcnt++;
          done_v = !b[7];
        end else begin
          p_vacc = (p_vacc << 8) | b;
          done_v = 1;
        end
        if (done_v) begin
          if (p_tcount >= MAX_FIELDS || p_vacc > TYPE_MAX) begin
            push_res(p_tcount, K_ERR, 0, 1, 1, n);
            p_phase = PH_DONE;
          end else begin
            p_types[p_tcount] = p_vacc[31:0];
            p_tcount++;
            p_vacc = 0;
            p_vcnt = 0;
            if (p_hread >= p_hlen) begin
              p_phase = PH_DATA;
              p_cur = 0;
              open_field();
              emit_empty(n, RES_LIMIT);
            end
          end
        end
      end
      PH_DATA: begin
        emit_empty(n, RES_LIMIT - 1);
        if (p_phase == PH_DATA && p_cur < p_tcount && p_remain != 0) begin
          take_data(b, n);
          emit_empty(n, RES_LIMIT);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // clock and cycle limit
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    field_res_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result idx/kind", {out_field_index, out_kind}, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_field_index !== w.idx) report_mismatch("field_index", out_field_index, w.idx);
        if (out_kind !== w.kind) report_mismatch("kind", out_kind, w.kind);
        if (out_field_value !== w.value) report_mismatch("field_value", out_field_value, w.value);
        if (out_last_of_field !== w.lf) report_mismatch("last_of_field", out_last_of_field, w.lf);
        if (out_last_of_record !== w.lr)
          report_mismatch("last_of_record", out_last_of_record, w.lr);
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // send one byte, with random idle cycles before it; valid stays high after
  // the transfer until the next byte or an idle cycle replaces it
  task automatic send_byte(logic [7:0] b, bit first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_first_of_cell <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, first);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // cell builder
  logic [7:0] cell_q[$];

  task automatic add_varint(logic [63:0] v);
    logic [6:0] grp[$];
    if (v == 0) begin
      cell_q.push_back(8'h00);
      return;
    end
    while (v != 0) begin
      grp.push_front(v[6:0]);
      v = v >> 7;
    end
    for (int i = 0; i < grp.size(); i++)
      cell_q.push_back({i != grp.size() - 1, grp[i]});
  endtask

  task automatic send_cell();
    foreach (cell_q[i]) send_byte(cell_q[i], i == 0);
    cell_q.delete();
  endtask

  function automatic int unsigned rand_type();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(11);
    if (sel < 8) return 12 + $urandom_range(7);
    if (sel == 8) return 12 + $urandom_range(1);
    return $urandom_range(13, 40);
  endfunction

  // build a well-formed cell from a list of serial types
  task automatic build_record(int unsigned types[$]);
    int unsigned hl;
    logic [7:0] hdr[$];
    logic [7:0] saved[$];
    saved = cell_q;
    cell_q.delete();
    foreach (types[i]) add_varint(types[i]);
    hdr = cell_q;
    cell_q = saved;
    hl = hdr.size() + 1;
    if ($urandom_range(1)) add_varint($urandom);
    else add_varint({$urandom, $urandom} >> 8);
    add_varint($urandom_range(300));
    cell_q.push_back(hl[7:0]);
    foreach (hdr[i]) cell_q.push_back(hdr[i]);
    foreach (types[i])
      repeat (byte_count(types[i])) cell_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic test_fixed_types();
    int unsigned t[$];
    t = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15};
    build_record(t);
    send_cell();
    // sign extremes
    cell_q = '{8'h05, 8'h01, 8'h04, 8'h01, 8'h06, 8'h06, 8'h80,
               8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_cell();
    cell_q = '{8'h03, 8'h02, 8'h02, 8'h01, 8'h7F};
    send_cell();
    wait_drained();
  endtask

  task automatic test_special_cases();
    // nine-byte row id ending the varint on its ninth byte
    cell_q = '{8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
               8'h02, 8'h09};
    send_cell();
    // short headers and trailing bytes
    cell_q = '{8'h01, 8'h01, 8'h00, 8'hAA, 8'h55};
    send_cell();
    cell_q = '{8'h01, 8'h01, 8'h01, 8'hAA};
    send_cell();
    // oversized type
    cell_q = '{8'h01, 8'h01, 8'h04, 8'h90, 8'h80, 8'h00, 8'h11};
    send_cell();
    // header overrun: type varint continues past header length
    cell_q = '{8'h01, 8'h01, 8'h02, 8'h81, 8'h00, 8'h01};
    send_cell();
    // nine-byte serial type varint, all 8 bits on the last byte
    cell_q = '{8'h01, 8'h01, 8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
               8'h80, 8'h0B, 8'h00};
    send_cell();
    // too many fields
    cell_q = '{8'h01, 8'h01, 8'd18};
    repeat (17) cell_q.push_back(8'h00);
    cell_q.push_back(8'h33);
    send_cell();
    // first_of_cell mid-record restarts
    cell_q = '{8'h01, 8'h01, 8'h02, 8'h06, 8'h12};
    foreach (cell_q[i]) send_byte(cell_q[i], i == 0);
    cell_q.delete();
    cell_q = '{8'h01, 8'h01, 8'h02, 8'h0E, 8'hFE};
    send_cell();
    wait_drained();
  endtask

  task automatic test_random_records(int unsigned n_bytes);
    int unsigned t[$];
    int unsigned sent;
    int unsigned nf;
    sent = 0;
    while (sent < n_bytes) begin
      t.delete();
      if ($urandom_range(9) == 0) begin
        // noise
        repeat ($urandom_range(1, 12)) cell_q.push_back(8'($urandom_range(255)));
      end else begin
        nf = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_FIELDS) : $urandom_range(1, 5);
        repeat (nf) t.push_back(rand_type());
        build_record(t);
        if ($urandom_range(9) == 0) void'(cell_q.pop_back());
      end
      sent += cell_q.size();
      send_cell();
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    int unsigned t[$];
    t = '{12, 13, 1, 0, 9, 14, 15};
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        build_record(t);
        send_cell();
        in_valid <= 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data_byte = 0;
    in_first_of_cell = 0;
    out_ready = 0;
    hold_off = 0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    clear_parser();
    repeat (9) @(negedge clk);
    rst_n = 1;

    test_fixed_types();
    test_special_cases();
    test_backpressure();
    test_random_records(12);
    send_idle_pct = 70;
    test_random_records(12);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    test_random_records(12);
    send_idle_pct = 11;
    recv_stall_pct = 11;
    test_random_records(12);

    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: record_field_decoder.f
rtl/rfd_pkg.sv
rtl/rfd_ctrl.sv
rtl/rfd_datapath.sv
rtl/record_field_decoder.sv
verif/tb_top.sv
